@@ src/spg_pkg.sv @@
package spg_pkg;

	localparam int PPR_W      = 16;
	localparam int RPM_W      = 12;
	localparam int PHT_W      = 6;
	localparam int ANGLE_W    = 16;
	localparam int TICK_W     = 20;
	localparam int PULSE_W    = 21;
	localparam int HIGH_W     = 3;
	localparam int PROD_W     = ANGLE_W + PPR_W;
	localparam int SPEED_W    = RPM_W + PPR_W;
	localparam int PNUM_W     = PROD_W - 4;
	localparam int RECIP_W    = 29;
	localparam int RECIP_SH   = 36;
	localparam int DIV_NUM_W  = 26;
	localparam int DIV_DEN_W  = SPEED_W;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_PPR = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RPM = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PHT = 2'd2;

	localparam logic [PPR_W-1:0] PPR_RST = 16'd1600;
	localparam logic [RPM_W-1:0] RPM_RST = 12'd1000;
	localparam logic [PHT_W-1:0] PHT_RST = 6'd25;

	localparam int DIR_SETUP_TICKS_DEF = 10;

	localparam logic CMD_TICK  = 1'b0;
	localparam logic CMD_START = 1'b1;

	localparam logic [PROD_W-1:0]    ROUND_BIAS = 32'd1800;
	// (x + 1800) / 3600 as ((x + 1800) >> 4) / 225, the last by reciprocal 2^36 / 225
	localparam logic [RECIP_W-1:0]   RECIP_225  = 29'd305419897;
	localparam logic [DIV_NUM_W-1:0] US_PER_MIN = 26'd60000000;
	localparam logic [TICK_W-1:0]    TICK_MAX   = '1;

	typedef struct packed {
		logic               cmd;
		logic               direction;
		logic [ANGLE_W-1:0] angle_tenths_deg;
	} in_t;

	typedef struct packed {
		logic dir_level;
		logic step_level;
		logic busy_res;
	} out_t;

	typedef struct packed {
		logic               is_start;
		logic               direction;
		logic [ANGLE_W-1:0] angle;
	} item_t;

	typedef struct packed {
		logic [PPR_W-1:0] ppr;
		logic [RPM_W-1:0] rpm;
		logic [PHT_W-1:0] pht;
	} cfg_t;

	typedef struct packed {
		logic                 go;
		logic [DIV_NUM_W-1:0] num;
		logic [DIV_DEN_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic                 busy;
		logic                 done;
		logic [DIV_NUM_W-1:0] quo;
	} div_rsp_t;

	typedef enum logic [3:0] {
		PH_IDLE  = 4'b0001,
		PH_SETUP = 4'b0010,
		PH_HIGH  = 4'b0100,
		PH_LOW   = 4'b1000
	} phase_t;

	// x / 10 for x below 70, by reciprocal 205 / 2048
	function automatic logic [HIGH_W-1:0] div10(input logic [PHT_W:0] x);
		logic [17:0] p;
		p = {11'b0, x} * 18'd205;
		return p[11+HIGH_W-1:11];
	endfunction

endpackage

@@ src/spg_front.sv @@
module spg_front import spg_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  in_t   in_item,
	input  logic  pop,
	output logic  item_valid,
	output item_t item
);

	logic [1:0] cnt_q;
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	item_t      mem_q [2];
	logic       push;
	logic       pull;

	assign in_ready   = (cnt_q != 2'd2);
	assign item_valid = (cnt_q != 2'd0);
	assign push       = in_valid && in_ready;
	assign pull       = pop && item_valid;
	assign item       = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= 2'd0;
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pull) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pull) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pull && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= '{
				is_start:  (in_item.cmd == CMD_START),
				direction: in_item.direction,
				angle:     in_item.angle_tenths_deg
			};
		end
	end

endmodule

@@ src/spg_div.sv @@
module spg_div import spg_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	localparam int CNT_W = $clog2(DIV_NUM_W + 1);

	logic                 running_q;
	logic                 done_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [DIV_DEN_W-1:0] den_q;
	logic [DIV_DEN_W-1:0] rem_q;
	logic [DIV_NUM_W-1:0] quo_q;
	logic [DIV_DEN_W:0]   rem_sh;
	logic [DIV_DEN_W:0]   rem_diff;
	logic                 fits;
	logic                 load;

	assign load     = req.go && !running_q;
	assign rem_sh   = {rem_q, quo_q[DIV_NUM_W-1]};
	assign rem_diff = rem_sh - {1'b0, den_q};
	assign fits     = (rem_sh >= {1'b0, den_q});

	assign rsp = '{busy: running_q, done: done_q, quo: quo_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= 1'b0;
			done_q    <= 1'b0;
			cnt_q     <= '0;
		end else if (load) begin
			running_q <= 1'b1;
			done_q    <= 1'b0;
			cnt_q     <= CNT_W'(DIV_NUM_W);
		end else if (running_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				running_q <= 1'b0;
				done_q    <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			den_q <= req.den;
			rem_q <= '0;
			quo_q <= req.num;
		end else if (running_q) begin
			rem_q <= fits ? rem_diff[DIV_DEN_W-1:0] : rem_sh[DIV_DEN_W-1:0];
			quo_q <= {quo_q[DIV_NUM_W-2:0], fits};
		end
	end

endmodule

@@ src/spg_back.sv @@
module spg_back import spg_pkg::*; #(
	parameter int DIR_SETUP_TICKS = DIR_SETUP_TICKS_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     item_valid,
	input  item_t    item,
	output logic     pop,
	input  cfg_t     cfg,
	output div_req_t div_req,
	input  div_rsp_t div_rsp,
	output logic     out_valid,
	input  logic     out_ready,
	output out_t     out_item
);

	typedef enum logic [4:0] {
		ST_IDLE        = 5'b00001,
		ST_MUL         = 5'b00010,
		ST_PERIOD_GO   = 5'b00100,
		ST_PERIOD_WAIT = 5'b01000,
		ST_FIN         = 5'b10000
	} seq_t;

	seq_t                seq_q;
	phase_t              phase_q;
	logic [TICK_W-1:0]   ptl_q;
	logic [PULSE_W-1:0]  pulses_q;
	logic                dir_q;
	logic [HIGH_W-1:0]   high_q;
	logic [TICK_W-1:0]   low_q;
	logic                out_valid_q;
	out_t                out_q;
	logic [ANGLE_W-1:0]  angle_q;
	logic                dir_new_q;
	logic [PNUM_W-1:0]   pnum_q;
	logic [SPEED_W-1:0]  speed_q;
	logic [PULSE_W-1:0]  npulse_q;

	logic                out_free;
	logic                take;
	logic                begin_move;
	logic                emit;
	phase_t              t_phase;
	logic [TICK_W-1:0]   t_ptl;
	logic [PULSE_W-1:0]  t_pulses;
	phase_t              u_phase;
	logic [TICK_W-1:0]   u_ptl;
	logic [PULSE_W-1:0]  u_pulses;
	logic [HIGH_W-1:0]   trunc_high;
	logic [HIGH_W-1:0]   round_high;
	logic [TICK_W-1:0]   per_raw;
	logic [TICK_W-1:0]   per;
	logic [TICK_W-1:0]   low_new;
	logic [PROD_W-1:0]   prod_sum;
	logic [PNUM_W+RECIP_W-1:0] recip_prod;

	assign out_free   = !out_valid_q || out_ready;
	assign take       = (seq_q == ST_IDLE) && item_valid && out_free;
	assign begin_move = take && item.is_start && (phase_q == PH_IDLE);
	assign emit       = (take && !begin_move) || ((seq_q == ST_FIN) && out_free);
	assign pop        = take;
	assign out_valid  = out_valid_q;
	assign out_item   = out_q;

	assign prod_sum   = PROD_W'(angle_q) * PROD_W'(cfg.ppr) + ROUND_BIAS;
	assign recip_prod = (PNUM_W+RECIP_W)'(pnum_q) * (PNUM_W+RECIP_W)'(RECIP_225);

	always_comb begin
		t_phase  = phase_q;
		t_ptl    = ptl_q;
		t_pulses = pulses_q;
		if (phase_q != PH_IDLE) begin
			if (ptl_q != '0) begin
				t_ptl = ptl_q - TICK_W'(1);
			end
			if (t_ptl == '0) begin
				if (phase_q == PH_HIGH) begin
					t_phase = PH_LOW;
					t_ptl   = low_q;
				end else if (pulses_q == '0) begin
					t_phase = PH_IDLE;
				end else begin
					t_pulses = pulses_q - PULSE_W'(1);
					if (high_q != '0) begin
						t_phase = PH_HIGH;
						t_ptl   = TICK_W'(high_q);
					end else begin
						t_phase = PH_LOW;
						t_ptl   = low_q;
					end
				end
			end
		end
	end

	always_comb begin
		if (item.is_start) begin
			u_phase  = phase_q;
			u_ptl    = ptl_q;
			u_pulses = pulses_q;
		end else begin
			u_phase  = t_phase;
			u_ptl    = t_ptl;
			u_pulses = t_pulses;
		end
	end

	always_comb begin
		trunc_high = div10({1'b0, cfg.pht});
		round_high = div10({1'b0, cfg.pht} + (PHT_W+1)'(5));
		if (speed_q == '0 || div_rsp.quo > DIV_NUM_W'(TICK_MAX)) begin
			per_raw = TICK_MAX;
		end else begin
			per_raw = div_rsp.quo[TICK_W-1:0];
		end
		if (per_raw <= TICK_W'(trunc_high) + TICK_W'(1)) begin
			per = TICK_W'(trunc_high) + TICK_W'(2);
		end else begin
			per = per_raw;
		end
		low_new = per - TICK_W'(trunc_high);
	end

	always_comb begin
		div_req = '{go: 1'b0, num: US_PER_MIN, den: speed_q};
		case (seq_q)
			ST_PERIOD_GO: begin
				div_req.go = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q       <= ST_IDLE;
			phase_q     <= PH_IDLE;
			ptl_q       <= '0;
			pulses_q    <= '0;
			dir_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (seq_q)
				ST_IDLE: begin
					if (begin_move) begin
						seq_q <= ST_MUL;
					end else if (take) begin
						phase_q  <= u_phase;
						ptl_q    <= u_ptl;
						pulses_q <= u_pulses;
					end
				end
				ST_MUL: begin
					seq_q <= ST_PERIOD_GO;
				end
				ST_PERIOD_GO: begin
					seq_q <= ST_PERIOD_WAIT;
				end
				ST_PERIOD_WAIT: begin
					if (div_rsp.done) begin
						seq_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						seq_q    <= ST_IDLE;
						phase_q  <= PH_SETUP;
						ptl_q    <= TICK_W'(DIR_SETUP_TICKS);
						pulses_q <= npulse_q;
						dir_q    <= dir_new_q;
					end
				end
				default: begin
					seq_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (begin_move) begin
			angle_q   <= item.angle;
			dir_new_q <= item.direction;
		end
		if (seq_q == ST_MUL) begin
			pnum_q  <= prod_sum[PROD_W-1:PROD_W-PNUM_W];
			speed_q <= SPEED_W'(cfg.rpm) * SPEED_W'(cfg.ppr);
		end
		if (seq_q == ST_PERIOD_GO) begin
			npulse_q <= recip_prod[RECIP_SH +: PULSE_W];
		end
		if (take && !begin_move) begin
			out_q <= '{
				dir_level:  dir_q,
				step_level: (u_phase == PH_HIGH),
				busy_res:   (u_phase != PH_IDLE)
			};
		end
		if (seq_q == ST_FIN && out_free) begin
			high_q <= round_high;
			low_q  <= low_new;
			out_q  <= '{dir_level: dir_new_q, step_level: 1'b0, busy_res: 1'b1};
		end
	end

endmodule

@@ src/stepper_step_dir_pulse_generator_top.sv @@
// Tick transaction: item registered in the queue, its result in the output register; one
// tick per cycle sustained while out_ready is high and no start is in progress. Start
// transaction on an idle block: result after the 26-step restoring divider for the pulse
// period; the step count is a reciprocal multiply. Start while busy: like a tick, but the
// pulse timing does not advance; levels unchanged. Reset (arst_n low) clears the queue,
// sequencer and pulse state at once, loads the default timing registers; no clearing pass.
module stepper_step_dir_pulse_generator_top import spg_pkg::*; #(
	parameter int DIR_SETUP_TICKS = DIR_SETUP_TICKS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  in_t                   in_item,
	output logic                  out_valid,
	input  logic                  out_ready,
	output out_t                  out_item,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t     cfg_q;
	logic     pop;
	logic     item_valid;
	item_t    item;
	div_req_t div_req;
	div_rsp_t div_rsp;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{ppr: PPR_RST, rpm: RPM_RST, pht: PHT_RST};
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_PPR: cfg_q.ppr <= cfg_data[PPR_W-1:0];
				CFG_RPM: cfg_q.rpm <= cfg_data[RPM_W-1:0];
				CFG_PHT: cfg_q.pht <= cfg_data[PHT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	spg_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_item    (in_item),
		.pop        (pop),
		.item_valid (item_valid),
		.item       (item)
	);

	spg_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	spg_back #(
		.DIR_SETUP_TICKS (DIR_SETUP_TICKS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item       (item),
		.pop        (pop),
		.cfg        (cfg_q),
		.div_req    (div_req),
		.div_rsp    (div_rsp),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_item   (out_item)
	);

endmodule

@@ src/spg_checker.sv @@
module spg_checker import spg_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic out_valid,
	input logic out_ready,
	input out_t out_item,
	input logic cfg_valid,
	input logic cfg_ready
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_item))
		else $error("stalled result transaction changed or dropped");

	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |-> !out_valid)
		else $error("result valid during reset");

	a_step_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.step_level |-> out_item.busy_res)
		else $error("step pulse high while not busy");

	a_cfg_taken: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration transaction stalled");

endmodule

bind stepper_step_dir_pulse_generator_top spg_checker u_spg_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_item  (out_item),
	.cfg_valid (cfg_valid),
	.cfg_ready (cfg_ready)
);
